/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

/* rtl/prte_pkg.sv */
// ----------------------------------------------------------------------------
// prte_pkg
// shared types and constants of the planar rigid transform engine
// ----------------------------------------------------------------------------
package prte_pkg;

    typedef enum logic [2:0] {
        ACT_LOAD    = 3'd0,
        ACT_COMPOSE = 3'd1,
        ACT_APPLY   = 3'd2,
        ACT_INVERT  = 3'd3,
        ACT_TWIST   = 3'd4
    } t_action;

    // one queued item
    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] arg_x;
        logic signed [31:0] arg_y;
        logic signed [15:0] arg_angle;
        logic signed [31:0] rate_w;
    } t_item;

    localparam logic signed [16:0] CosOne = 17'sd32768;
    localparam logic signed [33:0] GainQ30 = 34'sd652032874;

    // arctangent table in 32-bit turns
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

endpackage

/* rtl/prte_queue.sv */
// ----------------------------------------------------------------------------
// prte_queue
// two-entry item queue between the front and the back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module prte_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  prte_pkg::t_item  i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output prte_pkg::t_item  o_item
);
    prte_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, r_cnt == 2'd2 && !pop, r_cnt == 2'd2)
endmodule

/* rtl/prte_cordic.sv */
// ----------------------------------------------------------------------------
// prte_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module prte_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_angle,
    output logic               o_done,
    output logic signed [16:0] o_cos,
    output logic signed [16:0] o_sin
);
    localparam int StepW = $clog2(CORDIC_STEPS + 1);

    logic               r_busy, r_flip, r_done;
    logic [StepW-1:0]   r_i;
    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic signed [16:0] r_c, r_s;
    logic [31:0]        z0;
    logic signed [33:0] sx, sy, xr, yr;
    logic signed [16:0] cc, cs;
    logic signed [32:0] at;

    assign z0 = {i_angle, 16'h0};
    assign sx = r_x >>> r_i;
    assign sy = r_y >>> r_i;
    assign at = {1'b0, prte_pkg::atan_turns(5'(r_i))};

    // round to q1.15 and clamp
    function automatic logic signed [16:0] rnd(input logic signed [33:0] v);
        logic signed [33:0] t;
        begin
            t = (v + 34'sd16384) >>> 15;
            if (t > 34'sd32768) t = 34'sd32768;
            if (t < -34'sd32768) t = -34'sd32768;
            return t[16:0];
        end
    endfunction

    assign xr = r_x;
    assign yr = r_y;
    assign cc = r_flip ? -rnd(xr) : rnd(xr);
    assign cs = r_flip ? -rnd(yr) : rnd(yr);

    assign o_done = r_done;
    assign o_cos  = r_c;
    assign o_sin  = r_s;

    // iteration sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_c    <= prte_pkg::CosOne;
            r_s    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_angle == 16'sd0) begin
                    r_c    <= prte_pkg::CosOne;
                    r_s    <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_i    <= '0;
                    r_x    <= prte_pkg::GainQ30;
                    r_y    <= '0;
                    r_flip <= (z0[31:30] == 2'd1) || (z0[31:30] == 2'd2);
                    r_z    <= ((z0[31:30] == 2'd1) || (z0[31:30] == 2'd2))
                              ? 33'(signed'(z0 + 32'h80000000)) : 33'(signed'(z0));
                end
            end else if (r_busy) begin
                if (r_i == StepW'(CORDIC_STEPS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_c    <= cc;
                    r_s    <= cs;
                end else begin
                    if (!r_z[32]) begin
                        r_x <= r_x - sy;
                        r_y <= r_y + sx;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + sy;
                        r_y <= r_y - sx;
                        r_z <= r_z + at;
                    end
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end
endmodule

/* rtl/prte_back.sv */
// ----------------------------------------------------------------------------
// prte_back
// executes one queued item: products, sums, saturation, snap and pose update
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module prte_back #(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_snap,
    input  logic               i_valid,
    output logic               o_ready,
    input  prte_pkg::t_item    i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [15:0] o_angle,
    output logic signed [31:0] o_rate
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_FIN, S_TRIG, S_OUT} t_state;

    t_state             r_state;
    prte_pkg::t_item    r_it;
    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_pa;
    logic signed [16:0] r_pc, r_ps;
    logic signed [48:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [63:0] r_wx, r_wy;
    logic signed [31:0] r_rx, r_ry, r_rw;
    logic signed [15:0] r_ra;
    logic signed [49:0] r_sa, r_sb;
    logic               c_start, c_done;
    logic signed [15:0] c_ang;
    logic signed [16:0] c_cos, c_sin;
    logic signed [31:0] mx, my;
    logic signed [63:0] tx, ty;
    logic signed [63:0] ex, ey;
    logic signed [15:0] na;

    prte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(c_start), .i_angle(c_ang),
        .o_done(c_done), .o_cos(c_cos), .o_sin(c_sin)
    );

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] snp32(input logic signed [31:0] v,
                                                 input logic [15:0] t);
        logic signed [32:0] e, th;
        begin
            e  = 33'(v);
            th = 33'(signed'({1'b0, t}));
            return (e <= th && e >= -th) ? 32'sd0 : v;
        end
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_x = r_rx;
    assign o_y = r_ry;
    assign o_angle = r_ra;
    assign o_rate = r_rw;

    // operands per action: invert uses the pose, others the arguments
    assign mx = (r_it.action == prte_pkg::ACT_INVERT) ? r_px : r_it.arg_x;
    assign my = (r_it.action == prte_pkg::ACT_INVERT) ? r_py : r_it.arg_y;
    assign tx = 64'((r_sa + 50'sd16384) >>> 15);
    assign ty = 64'((r_sb + 50'sd16384) >>> 15);
    assign ex = (r_wx + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    assign ey = (r_wy + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    assign na = r_pa + r_it.arg_angle;
    assign c_start = (r_state == S_FIN) && (r_it.action == prte_pkg::ACT_LOAD
                     || r_it.action == prte_pkg::ACT_COMPOSE);
    assign c_ang = (r_it.action == prte_pkg::ACT_LOAD) ? r_it.arg_angle
                 : 16'(snp32(32'(na), i_snap));

    // execution sequencer and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_px <= '0; r_py <= '0; r_pa <= '0;
            r_pc <= prte_pkg::CosOne; r_ps <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_it <= i_item;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_m0 <= r_pc * mx; r_m1 <= r_ps * my;
                    r_m2 <= r_ps * mx; r_m3 <= r_pc * my;
                    r_wx <= r_py * r_it.rate_w;
                    r_wy <= r_px * r_it.rate_w;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_it.action == prte_pkg::ACT_INVERT) begin
                        r_sa <= -(50'(r_m0) + 50'(r_m1));
                        r_sb <= 50'(r_m2) - 50'(r_m3);
                    end else begin
                        r_sa <= 50'(r_m0) - 50'(r_m1);
                        r_sb <= 50'(r_m2) + 50'(r_m3);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_rx <= '0; r_ry <= '0; r_ra <= '0; r_rw <= '0;
                    r_state <= S_OUT;
                    unique case (r_it.action)
                        prte_pkg::ACT_LOAD: begin
                            r_rx <= r_it.arg_x; r_ry <= r_it.arg_y;
                            r_ra <= r_it.arg_angle;
                            r_px <= r_it.arg_x; r_py <= r_it.arg_y;
                            r_pa <= r_it.arg_angle;
                            r_state <= S_TRIG;
                        end
                        prte_pkg::ACT_COMPOSE: begin
                            r_rx <= snp32(sat(tx + 64'(r_px)), i_snap);
                            r_ry <= snp32(sat(ty + 64'(r_py)), i_snap);
                            r_ra <= c_ang;
                            r_px <= snp32(sat(tx + 64'(r_px)), i_snap);
                            r_py <= snp32(sat(ty + 64'(r_py)), i_snap);
                            r_pa <= c_ang;
                            r_state <= S_TRIG;
                        end
                        prte_pkg::ACT_APPLY: begin
                            r_rx <= snp32(sat(tx + 64'(r_px)), i_snap);
                            r_ry <= snp32(sat(ty + 64'(r_py)), i_snap);
                        end
                        prte_pkg::ACT_INVERT: begin
                            r_rx <= snp32(sat(tx), i_snap);
                            r_ry <= snp32(sat(ty), i_snap);
                            r_ra <= 16'(snp32(32'(16'sd0 - r_pa), i_snap));
                        end
                        prte_pkg::ACT_TWIST: begin
                            r_rx <= snp32(sat(tx + ex), i_snap);
                            r_ry <= snp32(sat(ty - ey), i_snap);
                            r_rw <= snp32(r_it.rate_w, i_snap);
                        end
                        default: ;
                    endcase
                end
                S_TRIG: if (c_done) begin
                    r_pc <= c_cos; r_ps <= c_sin;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, ##1 $stable(o_x))
    `ASSERT_IMPL(a_snap_rate, i_clk, i_rst_n,
        o_valid && r_it.action != prte_pkg::ACT_TWIST, o_rate == 32'sd0)
    `ASSERT_NEXT(a_trig_done, i_clk, i_rst_n, c_done && r_state == S_TRIG, r_state == S_OUT)
endmodule

/* rtl/planar_rigid_transform_engine.sv */
// ----------------------------------------------------------------------------
// planar_rigid_transform_engine
// holds one planar rigid transform and loads, composes, applies, inverts
// and maps twists through it in fixed point
// ----------------------------------------------------------------------------
// An item enters a two-entry queue whenever it has room and is executed by the
// back end in S_MUL, S_SUM and S_FIN, then in the result state S_OUT; the back
// end takes its next item only once the result is taken. Load and compose also
// wait for the cordic, which skips iterating for a zero angle and otherwise runs
// one micro-rotation per cycle. Results wait in an output register until taken.
module planar_rigid_transform_engine #(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_action,
    input  logic signed [31:0] i_arg_x,
    input  logic signed [31:0] i_arg_y,
    input  logic signed [15:0] i_arg_angle,
    input  logic signed [31:0] i_rate_w,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [15:0] o_out_angle,
    output logic signed [31:0] o_out_rate
);
    logic [15:0]     r_snap;
    prte_pkg::t_item in_item, q_item;
    logic            q_valid, q_ready;

    assign o_cfg_ready = 1'b1;
    assign in_item = '{action: i_action, arg_x: i_arg_x, arg_y: i_arg_y,
                       arg_angle: i_arg_angle, rate_w: i_rate_w};

    // snap threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_snap <= '0;
        else if (i_cfg_valid) r_snap <= i_cfg_data;
    end

    prte_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(in_item), .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    prte_back #(.CORDIC_STEPS(CORDIC_STEPS), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_snap(r_snap),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_x(o_out_x), .o_y(o_out_y), .o_angle(o_out_angle), .o_rate(o_out_rate)
    );
endmodule
